>>> hdl/vsd_pkg.sv
// ----------------------------------------------------------------------------
// Videotex stream decoder package
// Shared result type, attribute layout constants and the G2 accent table.
// ----------------------------------------------------------------------------
package vsd_pkg;

  localparam int unsigned DefCols = 40;
  localparam int unsigned DefRows = 25;

  localparam logic [13:0] AttrReset = 14'd7;
  localparam int unsigned MaxResults = 63;

  typedef struct packed {
    logic       kind;
    logic [9:0] cell_index;
    logic [6:0] char_code;
    logic [2:0] fg_color;
    logic [2:0] bg_color;
    logic [1:0] font_set;
    logic [5:0] style_flags;
    logic       last;
  } vsd_res_t;

  // Returns {hit, code}. A pair lookup is used when is_pair is set.
  function automatic logic [7:0] vsd_g2_lookup(input logic is_pair, input logic [7:0] b0,
                                               input logic [7:0] b1);
    logic [7:0] res;
    res = 8'h00;
    if (!is_pair) begin
      case (b0)
        8'h6A: res = {1'b1, 7'd10};
        8'h2C: res = {1'b1, 7'd12};
        8'h23: res = {1'b1, 7'd13};
        8'h2E: res = {1'b1, 7'd14};
        8'h2F: res = {1'b1, 7'd15};
        8'h30: res = {1'b1, 7'd16};
        8'h31: res = {1'b1, 7'd17};
        8'h7A: res = {1'b1, 7'd26};
        8'h3C: res = {1'b1, 7'd28};
        8'h3D: res = {1'b1, 7'd29};
        8'h3E: res = {1'b1, 7'd30};
        8'h2D: res = {1'b1, 7'd94};
        8'h7B: res = {1'b1, 7'd31};
        default: res = 8'h00;
      endcase
    end else begin
      case ({b0, b1})
        16'h4161: res = {1'b1, 7'd0};
        16'h4165: res = {1'b1, 7'd1};
        16'h4175: res = {1'b1, 7'd2};
        16'h4265: res = {1'b1, 7'd5};
        16'h4361: res = {1'b1, 7'd7};
        16'h4365: res = {1'b1, 7'd8};
        16'h4369: res = {1'b1, 7'd11};
        16'h436F: res = {1'b1, 7'd18};
        16'h4375: res = {1'b1, 7'd19};
        16'h4865: res = {1'b1, 7'd22};
        16'h4869: res = {1'b1, 7'd23};
        16'h4B63: res = {1'b1, 7'd25};
        16'h4261: res = {1'b1, 7'd97};
        16'h4861: res = {1'b1, 7'd97};
        16'h4169: res = {1'b1, 7'd105};
        16'h4269: res = {1'b1, 7'd105};
        16'h416F: res = {1'b1, 7'd111};
        16'h426F: res = {1'b1, 7'd111};
        16'h486F: res = {1'b1, 7'd111};
        16'h4275: res = {1'b1, 7'd117};
        16'h4875: res = {1'b1, 7'd117};
        default: res = 8'h00;
      endcase
    end
    return res;
  endfunction

endpackage

>>> hdl/videotex_stream_decoder.sv
// ----------------------------------------------------------------------------
// Videotex stream decoder
// Turns a Videotex byte stream into screen cell writes.
// ----------------------------------------------------------------------------
// The input channel takes one received byte per request on rx_byte_i. The
// output channel gives one cell write per request, or a single page-clear
// result for a form feed; last_o marks the final result caused by a byte.
// A printable byte is decoded in S_DEC after acceptance and its result is
// pushed into the output register from S_WRITE; in_ready_o is high only in
// S_IDLE, so a new byte is taken only once the last one is handled. Repeat and
// clear-to-end-of-line emit one cell write per cycle while the output register
// has room (up to 63 reported). US positioning reads the width map one cell at
// a time, for up to COLS cells. A page clear, and reset, sweep the width map
// one cell per cycle over all COLS*ROWS cells (1000 by default), during which
// no byte is taken. The sequencer waits whenever it has a result to push and
// the output register is full and not being taken, so a stalled receiver
// simply holds the decoder.
// ----------------------------------------------------------------------------
module videotex_stream_decoder #(
  parameter int unsigned COLS = vsd_pkg::DefCols,
  parameter int unsigned ROWS = vsd_pkg::DefRows
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [9:0] cell_index_o,
  output logic [6:0] char_code_o,
  output logic [2:0] fg_color_o,
  output logic [2:0] bg_color_o,
  output logic [1:0] font_set_o,
  output logic [5:0] style_flags_o,
  output logic       last_o
);

  logic              push, space;
  vsd_pkg::vsd_res_t res_new, res_out;

  vsd_core #(
    .Cols(COLS),
    .Rows(ROWS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .rx_byte_i (rx_byte_i),
    .space_i   (space),
    .push_o    (push),
    .res_o     (res_new)
  );

  vsd_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res_i      (res_new),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign kind_o        = res_out.kind;
  assign cell_index_o  = res_out.cell_index;
  assign char_code_o   = res_out.char_code;
  assign fg_color_o    = res_out.fg_color;
  assign bg_color_o    = res_out.bg_color;
  assign font_set_o    = res_out.font_set;
  assign style_flags_o = res_out.style_flags;
  assign last_o        = res_out.last;

endmodule

>>> hdl/vsd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module vsd_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> hdl/vsd_out.sv
// ----------------------------------------------------------------------------
// Videotex decoder result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module vsd_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vsd_pkg::vsd_res_t res_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vsd_pkg::vsd_res_t res_o
);

  logic              valid_q, valid_d;
  vsd_pkg::vsd_res_t res_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> hdl/vsd_core.sv
// ----------------------------------------------------------------------------
// Videotex decoder sequencer
// Parses bytes, steps the cursor and drives cell writes and map sweeps.
// ----------------------------------------------------------------------------
module vsd_core #(
  parameter int unsigned Cols = vsd_pkg::DefCols,
  parameter int unsigned Rows = vsd_pkg::DefRows
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              space_i,
  output logic              push_o,
  output vsd_pkg::vsd_res_t res_o
);

  localparam int unsigned Cells = Cols * Rows;
  localparam int unsigned IdxW  = $clog2(Cells);
  localparam int unsigned ColW  = $clog2(Cols);
  localparam int unsigned RowW  = (Rows > 2) ? $clog2(Rows) : 1;
  localparam int unsigned CntW  = $clog2(Cols + 1);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_PAGE  = 3'd4;
  localparam logic [2:0] S_CRD   = 3'd5;
  localparam logic [2:0] S_CACC  = 3'd6;

  localparam logic [2:0] M_NORMAL = 3'd0;
  localparam logic [2:0] M_REPEAT = 3'd1;
  localparam logic [2:0] M_SKIP   = 3'd2;
  localparam logic [2:0] M_G2     = 3'd3;
  localparam logic [2:0] M_ESC    = 3'd4;
  localparam logic [2:0] M_US     = 3'd5;

  localparam logic [7:0] C_BS   = 8'h08;
  localparam logic [7:0] C_HT   = 8'h09;
  localparam logic [7:0] C_LF   = 8'h0A;
  localparam logic [7:0] C_VT   = 8'h0B;
  localparam logic [7:0] C_FF   = 8'h0C;
  localparam logic [7:0] C_CR   = 8'h0D;
  localparam logic [7:0] C_SO   = 8'h0E;
  localparam logic [7:0] C_SI   = 8'h0F;
  localparam logic [7:0] C_REP  = 8'h12;
  localparam logic [7:0] C_SKIP = 8'h13;
  localparam logic [7:0] C_SS2  = 8'h16;
  localparam logic [7:0] C_CAN  = 8'h18;
  localparam logic [7:0] C_SS3  = 8'h19;
  localparam logic [7:0] C_ESC  = 8'h1B;
  localparam logic [7:0] C_RS   = 8'h1E;
  localparam logic [7:0] C_US   = 8'h1F;

  localparam logic [ColW-1:0] LastCol = ColW'(Cols - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(Rows - 1);
  localparam logic [6:0]      Space   = 7'h20;

  logic [2:0]      state_q, state_d;
  logic [2:0]      mode_q, mode_d;
  logic [1:0]      step_q, step_d;
  logic [7:0]      held_q, held_d;
  logic [7:0]      byte_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [13:0]     attr_q, attr_d;
  logic [6:0]      prev_q, prev_d;
  logic [6:0]      wchar_q, wchar_d;
  logic [13:0]     wattr_q, wattr_d;
  logic [6:0]      rem_q, rem_d;
  logic [5:0]      nres_q, nres_d;
  logic [IdxW-1:0] sweep_q, sweep_d;
  logic            fill_q, fill_d;
  logic [7:0]      pc_q, pc_d;
  logic [RowW-1:0] pr_q, pr_d;
  logic [CntW-1:0] lim_q, lim_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            accept;
  logic            ram_we, ram_wdata, ram_rdata;
  logic [IdxW-1:0] ram_addr, cur_idx;
  logic            report;

  function automatic logic [13:0] esc_attr(input logic [13:0] a, input logic [7:0] c);
    logic [13:0] r;
    r = a;
    case (c)
      8'h48: r[11] = 1'b1;
      8'h49: r[11] = 1'b0;
      8'h4C: r[9:8] = 2'b00;
      8'h4D: r[9:8] = 2'b10;
      8'h4E: r[9:8] = 2'b01;
      8'h4F: r[9:8] = 2'b11;
      8'h58: r[13] = 1'b1;
      8'h59: r[12] = 1'b0;
      8'h5A: r[12] = 1'b1;
      8'h5C: r[10] = 1'b0;
      8'h5D: r[10] = 1'b1;
      8'h5F: r[13] = 1'b0;
      default: begin
        if (c[7:3] == 5'b01000) begin
          r[2:0] = c[2:0];
        end else if (c[7:3] == 5'b01010) begin
          r[5:3] = c[2:0];
        end
      end
    endcase
    return r;
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign cur_idx    = IdxW'(row_q) * IdxW'(Cols) + IdxW'(col_q);
  assign report     = (nres_q != 6'(vsd_pkg::MaxResults));

  always_comb begin
    logic [7:0]      c;
    logic [1:0]      stepn;
    logic [7:0]      g2;
    logic [7:0]      rc;
    logic [7:0]      y, x;
    logic [7:0]      pcn, prn, pc2;
    logic            go;

    c     = byte_q;
    stepn = step_q + 2'd1;
    g2    = 8'h00;
    rc    = 8'h00;
    y     = held_q;
    x     = c;
    pcn   = 8'h00;
    prn   = 8'h00;
    pc2   = 8'h00;
    go    = 1'b0;

    state_d = state_q;
    mode_d  = mode_q;
    step_d  = step_q;
    held_d  = held_q;
    col_d   = col_q;
    row_d   = row_q;
    attr_d  = attr_q;
    prev_d  = prev_q;
    wchar_d = wchar_q;
    wattr_d = wattr_q;
    rem_d   = rem_q;
    nres_d  = nres_q;
    sweep_d = sweep_q;
    fill_d  = fill_q;
    pc_d    = pc_q;
    pr_d    = pr_q;
    lim_d   = lim_q;
    i_d     = i_q;
    cnt_d   = cnt_q;

    ram_we    = 1'b0;
    ram_wdata = fill_q;
    ram_addr  = sweep_q;
    push_o    = 1'b0;
    res_o     = '0;

    case (state_q)
      S_SWEEP: begin
        ram_we = 1'b1;
        if (sweep_q == IdxW'(Cells - 1)) begin
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_d = S_DEC;
          nres_d  = '0;
        end
      end

      S_DEC: begin
        state_d = S_IDLE;
        case (mode_q)
          M_REPEAT: begin
            mode_d  = M_NORMAL;
            rc      = c - 8'h40;
            wchar_d = prev_q;
            wattr_d = attr_q;
            rem_d   = (rc > 8'd63) ? 7'd63 : rc[6:0];
            if (rc != 8'h00) begin
              state_d = S_WRITE;
            end
          end
          M_SKIP: begin
            mode_d = M_NORMAL;
          end
          M_G2: begin
            step_d = stepn;
            if (stepn == 2'd1) begin
              held_d = c;
              g2     = vsd_pkg::vsd_g2_lookup(1'b0, c, c);
            end else begin
              g2     = vsd_pkg::vsd_g2_lookup(1'b1, held_q, c);
              mode_d = M_NORMAL;
            end
            if (g2[7]) begin
              mode_d  = M_NORMAL;
              wchar_d = g2[6:0];
              wattr_d = {attr_q[13:8], 2'd2, attr_q[5:0]};
              rem_d   = 7'd1;
              state_d = S_WRITE;
            end
          end
          M_ESC: begin
            attr_d = esc_attr(attr_q, c);
            mode_d = M_NORMAL;
          end
          M_US: begin
            step_d = stepn;
            if (stepn == 2'd1) begin
              held_d = c;
            end else begin
              mode_d = M_NORMAL;
              if (y >= 8'h30 && y <= 8'h32) begin
                pcn = 8'h00;
                prn = 8'((y - 8'h30) * 8'd10) + (x - 8'h30);
              end else begin
                pcn = x - 8'h41;
                prn = y - 8'h40;
              end
              pc_d  = pcn;
              pr_d  = RowW'(prn);
              lim_d = (pcn < 8'(Cols)) ? CntW'(pcn) : CntW'(Cols);
              i_d   = '0;
              cnt_d = '0;
              if (prn < 8'(Rows) && pcn != 8'h00) begin
                state_d = S_CRD;
              end else begin
                col_d  = (pcn >= 8'(Cols)) ? LastCol : ColW'(pcn);
                row_d  = (prn >= 8'(Rows)) ? LastRow : RowW'(prn);
                attr_d = vsd_pkg::AttrReset;
              end
            end
          end
          default: begin
            mode_d = M_NORMAL;
            if (c >= 8'h20 && c <= 8'h7F) begin
              wchar_d = c[6:0];
              wattr_d = attr_q;
              rem_d   = 7'd1;
              state_d = S_WRITE;
            end else begin
              step_d = 2'd0;
              held_d = c;
              case (c)
                C_BS: begin
                  if (col_q == '0) begin
                    col_d = LastCol;
                    if (row_q != '0) begin
                      row_d = row_q - 1'b1;
                    end
                  end else begin
                    col_d = col_q - 1'b1;
                  end
                end
                C_HT: begin
                  if (col_q == LastCol) begin
                    col_d = '0;
                    if (row_q != LastRow) begin
                      row_d = row_q + 1'b1;
                    end
                  end else begin
                    col_d = col_q + 1'b1;
                  end
                end
                C_LF: if (row_q != LastRow) row_d = row_q + 1'b1;
                C_VT: if (row_q != '0) row_d = row_q - 1'b1;
                C_FF: state_d = S_PAGE;
                C_CR: col_d = '0;
                C_SO: attr_d[7:6] = 2'd1;
                C_SI: attr_d[7:6] = 2'd0;
                C_REP: mode_d = M_REPEAT;
                C_SKIP: mode_d = M_SKIP;
                C_SS2: mode_d = M_G2;
                C_CAN: begin
                  wchar_d = Space;
                  wattr_d = {attr_q[13:8], 2'd0, attr_q[5:0]};
                  rem_d   = 7'(Cols) - 7'(col_q);
                  state_d = S_WRITE;
                end
                C_SS3: attr_d[7:6] = 2'd2;
                C_ESC: mode_d = M_ESC;
                C_RS: begin
                  col_d  = '0;
                  row_d  = RowW'(1);
                  attr_d = vsd_pkg::AttrReset;
                end
                C_US: mode_d = M_US;
                default: ;
              endcase
            end
          end
        endcase
      end

      S_WRITE: begin
        go       = !report || space_i;
        ram_addr = cur_idx;
        ram_wdata = wattr_q[8];
        if (go) begin
          ram_we = 1'b1;
          prev_d = wchar_q;
          if (report) begin
            push_o            = 1'b1;
            res_o.kind        = 1'b0;
            res_o.cell_index  = 10'(cur_idx);
            res_o.char_code   = wchar_q;
            res_o.fg_color    = wattr_q[2:0];
            res_o.bg_color    = wattr_q[5:3];
            res_o.font_set    = wattr_q[7:6];
            res_o.style_flags = wattr_q[13:8];
            res_o.last        = (rem_q == 7'd1) || (nres_q == 6'(vsd_pkg::MaxResults - 1));
            nres_d            = nres_q + 1'b1;
          end
          if (col_q == LastCol) begin
            col_d = '0;
            if (row_q != LastRow) begin
              row_d = row_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
          rem_d = rem_q - 1'b1;
          if (rem_q == 7'd1) begin
            state_d = S_IDLE;
          end
        end
      end

      S_PAGE: begin
        if (space_i) begin
          push_o            = 1'b1;
          res_o.kind        = 1'b1;
          res_o.cell_index  = '0;
          res_o.char_code   = Space;
          res_o.fg_color    = attr_q[2:0];
          res_o.bg_color    = attr_q[5:3];
          res_o.font_set    = attr_q[7:6];
          res_o.style_flags = attr_q[13:8];
          res_o.last        = 1'b1;
          fill_d            = attr_q[8];
          sweep_d           = '0;
          prev_d            = Space;
          col_d             = '0;
          row_d             = '0;
          attr_d            = vsd_pkg::AttrReset;
          state_d           = S_SWEEP;
        end
      end

      S_CRD: begin
        // Each map entry left of the target column is read, then added.
        ram_addr = IdxW'(pr_q) * IdxW'(Cols) + IdxW'(i_q);
        state_d  = S_CACC;
      end

      S_CACC: begin
        cnt_d = cnt_q + CntW'(ram_rdata);
        i_d   = i_q + 1'b1;
        if (i_q + 1'b1 == lim_q) begin
          pc2    = pc_q - 8'(cnt_d);
          col_d  = (pc2 >= 8'(Cols)) ? LastCol : ColW'(pc2);
          row_d  = pr_q;
          attr_d = vsd_pkg::AttrReset;
          state_d = S_IDLE;
        end else begin
          state_d = S_CRD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  vsd_ram #(
    .Width(1),
    .Depth(Cells)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      mode_q  <= M_NORMAL;
      step_q  <= '0;
      held_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      attr_q  <= vsd_pkg::AttrReset;
      prev_q  <= Space;
      rem_q   <= '0;
      nres_q  <= '0;
      sweep_q <= '0;
      fill_q  <= 1'b0;
      i_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      step_q  <= step_d;
      held_q  <= held_d;
      col_q   <= col_d;
      row_q   <= row_d;
      attr_q  <= attr_d;
      prev_q  <= prev_d;
      rem_q   <= rem_d;
      nres_q  <= nres_d;
      sweep_q <= sweep_d;
      fill_q  <= fill_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
    wchar_q <= wchar_d;
    wattr_q <= wattr_d;
    pc_q    <= pc_d;
    pr_q    <= pr_d;
    lim_q   <= lim_d;
  end

  a_push_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (state_q == S_WRITE || state_q == S_PAGE))
    else $error("result pushed outside a write or page clear");

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> space_i)
    else $error("result pushed into a full output register");

  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < Cols) && (32'(row_q) < Rows))
    else $error("cursor out of range");

  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DEC))
    else $error("accepted byte not decoded next");

  a_write_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (rem_q != 7'd0))
    else $error("write burst with nothing left");

endmodule
